// ===== rtl/laplacian_sharpen_3x3_assert.svh =====
// Assertion macros for the Laplacian sharpening block.
// Included by the top level; no other dependencies.
`ifndef LAPLACIAN_SHARPEN_3X3_ASSERT_SVH
`define LAPLACIAN_SHARPEN_3X3_ASSERT_SVH

`ifndef SYNTHESIS

`define LSH_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lsh assertion failed: implication");

`define LSH_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lsh assertion failed: next-cycle implication");

`else

`define LSH_ASSERT_IMPL(label, clk, rst, ante, cons)

`define LSH_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/lsh_pkg.sv =====
// Shared types and constants for the Laplacian sharpening block.
// No dependencies.
package lsh_pkg;

  localparam int SAMPLE_W  = 8;
  localparam int MAX_CH    = 4;
  localparam int RES_DEPTH = 4;

  // One result item.
  typedef struct packed {
    logic [SAMPLE_W-1:0] value;
    logic                last;
  } lsh_res_t;

  // Results handed from the compute stage to the output queue.
  typedef struct packed {
    logic [1:0] n;
    lsh_res_t   first;
    lsh_res_t   second;
  } lsh_push_t;

  // Frame geometry after clamping.
  typedef struct packed {
    logic [2:0]  ch_eff;
    logic [12:0] height;
    logic [11:0] last_row;
  } lsh_geom_t;

endpackage

// ===== rtl/lsh_line_mem.sv =====
// One line store: single write port, two registered read ports, read-first.
// Uses lsh_pkg for the sample width.
module lsh_line_mem
  import lsh_pkg::*;
#(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic                clk,
  input  logic                we,
  input  logic [AW-1:0]       waddr,
  input  logic [SAMPLE_W-1:0] wdata,
  input  logic                ren,
  input  logic [AW-1:0]       raddr_x,
  input  logic [AW-1:0]       raddr_y,
  output logic [SAMPLE_W-1:0] rdata_x,
  output logic [SAMPLE_W-1:0] rdata_y
);

  logic [SAMPLE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (ren) begin
      rdata_x <= mem[raddr_x];
      rdata_y <= mem[raddr_y];
    end
  end

endmodule

// ===== rtl/lsh_regs.sv =====
// APB configuration registers and the clamped frame geometry derived from them.
// Uses lsh_pkg for the geometry struct.
module lsh_regs
  import lsh_pkg::*;
#(
  parameter int MAX_LINE_SAMPLES = 4096,
  parameter int LW               = 13
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [3:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  output lsh_geom_t     geom,
  output logic [LW-1:0] line_len,
  output logic [LW-1:0] line_len_m_ch
);

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_CHAN   = 2'd2;
  localparam int CW = (LW > 13) ? LW : 13;
  localparam logic [LW-1:0] WMAX [MAX_CH] = '{
    LW'(MAX_LINE_SAMPLES / 1), LW'(MAX_LINE_SAMPLES / 2),
    LW'(MAX_LINE_SAMPLES / 3), LW'(MAX_LINE_SAMPLES / 4)
  };

  logic [12:0]   image_width, image_width_next;
  logic [12:0]   image_height, image_height_next;
  logic [2:0]    channel_count, channel_count_next;
  logic          wr_en;
  logic [1:0]    reg_idx;
  logic [2:0]    ch_c;
  logic [LW-1:0] wmax_c, wc_c, len_c;
  logic [12:0]   h_c;
  lsh_geom_t     geom_next;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[3:2];

  always_comb begin
    unique case (reg_idx)
      REG_WIDTH:  prdata = {19'd0, image_width};
      REG_HEIGHT: prdata = {19'd0, image_height};
      REG_CHAN:   prdata = {29'd0, channel_count};
      default:    prdata = 32'd0;
    endcase
  end

  always_comb begin
    image_width_next   = image_width;
    image_height_next  = image_height;
    channel_count_next = channel_count;
    if (rst) begin
      image_width_next   = 13'd640;
      image_height_next  = 13'd480;
      channel_count_next = 3'd1;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_WIDTH:  image_width_next   = pwdata[12:0];
        REG_HEIGHT: image_height_next  = pwdata[12:0];
        REG_CHAN:   channel_count_next = pwdata[2:0];
        default:    ;
      endcase
    end

    // Clamp channels to 1..4, width to 1..(line depth / channels), height to 1..4096.
    if (channel_count_next == 3'd0) begin
      ch_c = 3'd1;
    end else if (channel_count_next > 3'd4) begin
      ch_c = 3'd4;
    end else begin
      ch_c = channel_count_next;
    end
    wmax_c = WMAX[2'(ch_c - 3'd1)];
    if (CW'(image_width_next) > CW'(wmax_c)) begin
      wc_c = wmax_c;
    end else begin
      wc_c = LW'(image_width_next);
    end
    if (wc_c == '0) begin
      wc_c = LW'(1);
    end
    len_c = LW'(wc_c * LW'(ch_c));

    if (image_height_next == 13'd0) begin
      h_c = 13'd1;
    end else if (image_height_next > 13'd4096) begin
      h_c = 13'd4096;
    end else begin
      h_c = image_height_next;
    end

    geom_next.ch_eff   = ch_c;
    geom_next.height   = h_c;
    geom_next.last_row = 12'(h_c - 13'd1);
  end

  // rst is folded into the next values above.
  always_ff @(posedge clk) begin
    image_width   <= image_width_next;
    image_height  <= image_height_next;
    channel_count <= channel_count_next;
    geom          <= geom_next;
    line_len      <= len_c;
    line_len_m_ch <= len_c - LW'(ch_c);
  end

endmodule

// ===== rtl/lsh_out_fifo.sv =====
// Result queue: takes up to two results per cycle, delivers one.
// Uses lsh_pkg for the result and push structs.
module lsh_out_fifo
  import lsh_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  lsh_push_t push,
  output logic      space_two,
  output logic      res_valid,
  input  logic      res_ready,
  output lsh_res_t  res
);

  localparam int PW = $clog2(RES_DEPTH);
  localparam int CW = $clog2(RES_DEPTH + 1);

  lsh_res_t        ent [RES_DEPTH];
  logic [PW-1:0]   wp, rp;
  logic [CW-1:0]   count;
  logic            pop;

  assign res_valid = (count != '0);
  assign res       = ent[rp];
  assign pop       = res_valid & res_ready;
  assign space_two = (count <= CW'(RES_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      wp    <= wp + PW'(push.n);
      rp    <= rp + PW'(pop);
      count <= count + CW'(push.n) - CW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      ent[wp] <= push.first;
    end
    if (push.n == 2'd2) begin
      ent[wp + PW'(1)] <= push.second;
    end
  end

endmodule

// ===== rtl/laplacian_sharpen_3x3.sv =====
// Streaming 3x3 Laplacian sharpening over interleaved 8-bit samples.
// Samples pass a registered compute stage, then the output queue. One sample
// per cycle while the queue has room for two results; last-row samples yield
// two results, so they pace slower. Rate is set by the one-result-per-cycle
// output queue. Per sample, both stores read and the current-row store writes at once.
// Reset (synchronous): position, row, store select and queue cleared; no clearing pass.
module laplacian_sharpen_3x3
  import lsh_pkg::*;
#(
  parameter int MAX_LINE_SAMPLES = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        sample_valid,
  output logic        sample_ready,
  input  logic [7:0]  sample,
  output logic        result_valid,
  input  logic        result_ready,
  output logic [7:0]  out_value,
  output logic        last_of_run
);

`include "laplacian_sharpen_3x3_assert.svh"

  localparam int AW = $clog2(MAX_LINE_SAMPLES);
  localparam int LW = $clog2(MAX_LINE_SAMPLES + 1);

  lsh_geom_t     geom;
  logic [LW-1:0] line_len, line_len_m_ch;

  lsh_regs #(
    .MAX_LINE_SAMPLES (MAX_LINE_SAMPLES),
    .LW               (LW)
  ) u_regs (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .geom          (geom),
    .line_len      (line_len),
    .line_len_m_ch (line_len_m_ch)
  );

  // Position state.
  logic [AW-1:0] col, col_next;
  logic [11:0]   row, row_next;
  logic          sel, sel_next;

  // Request-side decode.
  logic          accept;
  logic [AW-1:0] col0, addr_y;
  logic [11:0]   row0;
  logic [LW-1:0] col_inc;
  logic [12:0]   row_inc;
  logic          emit1, emit2, interior, wrap;

  // Compute stage.
  logic                s1_valid, s1_sel, s1_emit1, s1_emit2, s1_interior;
  logic [SAMPLE_W-1:0] s1_sample;
  logic                space_two, s1_go;
  logic [SAMPLE_W-1:0] a_x, a_y, b_x, b_y;
  logic [SAMPLE_W-1:0] up_c, mid_c, right_c, left_c;
  logic [SAMPLE_W-1:0] dline [MAX_CH];
  logic [10:0]         mid5;
  logic [11:0]         acc;
  logic [SAMPLE_W-1:0] sharp;
  lsh_push_t           push;
  lsh_res_t            res;

  assign s1_go        = s1_valid & space_two;
  assign sample_ready = ~s1_valid | space_two;
  assign accept       = sample_valid & sample_ready;

  always_comb begin
    col0 = (LW'(col) >= line_len) ? '0 : col;
    row0 = ({1'b0, row} >= geom.height) ? '0 : row;

    emit1    = (row0 != 12'd0);
    emit2    = (row0 == geom.last_row);
    interior = (row0 >= 12'd2) && (LW'(col0) >= LW'(geom.ch_eff))
               && (LW'(col0) < line_len_m_ch);
    addr_y   = AW'(LW'(col0) + LW'(geom.ch_eff));

    col_inc = LW'(col0) + LW'(1);
    wrap    = (col_inc == line_len);
    row_inc = {1'b0, row0} + 13'd1;

    col_next = col;
    row_next = row;
    sel_next = sel;
    if (accept) begin
      col_next = wrap ? '0 : AW'(col_inc);
      row_next = row0;
      if (wrap) begin
        sel_next = ~sel;
        row_next = (row_inc >= geom.height) ? 12'd0 : row_inc[11:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
      sel <= 1'b0;
    end else begin
      col <= col_next;
      row <= row_next;
      sel <= sel_next;
    end
  end

  // Store "sel" holds the current row; the other holds the previous one.
  lsh_line_mem #(.DEPTH(MAX_LINE_SAMPLES), .AW(AW)) u_store_a (
    .clk     (clk),
    .we      (accept & ~sel),
    .waddr   (col0),
    .wdata   (sample),
    .ren     (accept),
    .raddr_x (col0),
    .raddr_y (addr_y),
    .rdata_x (a_x),
    .rdata_y (a_y)
  );

  lsh_line_mem #(.DEPTH(MAX_LINE_SAMPLES), .AW(AW)) u_store_b (
    .clk     (clk),
    .we      (accept & sel),
    .waddr   (col0),
    .wdata   (sample),
    .ren     (accept),
    .raddr_x (col0),
    .raddr_y (addr_y),
    .rdata_x (b_x),
    .rdata_y (b_y)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_sample   <= sample;
      s1_sel      <= sel;
      s1_emit1    <= emit1;
      s1_emit2    <= emit2;
      s1_interior <= interior;
    end
  end

  // Read-first port x of the current-row store gives the sample two rows up.
  assign up_c    = s1_sel ? b_x : a_x;
  assign mid_c   = s1_sel ? a_x : b_x;
  assign right_c = s1_sel ? a_y : b_y;
  assign left_c  = dline[2'(geom.ch_eff - 3'd1)];

  // Keep the last few centre values to supply the left neighbour.
  always_ff @(posedge clk) begin
    if (s1_go) begin
      dline[0] <= mid_c;
      for (int i = 1; i < MAX_CH; i++) begin
        dline[i] <= dline[i-1];
      end
    end
  end

  always_comb begin
    mid5 = {1'b0, mid_c, 2'b00} + 11'(mid_c);
    acc  = 12'(mid5) - 12'(left_c) - 12'(right_c) - 12'(up_c) - 12'(s1_sample);
    if (acc[11]) begin
      sharp = '0;
    end else if (acc[10:8] != 3'd0) begin
      sharp = 8'hFF;
    end else begin
      sharp = acc[7:0];
    end

    push.second.value = '0;
    push.second.last  = 1'b1;
    if (s1_emit1) begin
      push.first.value = s1_interior ? sharp : '0;
      push.first.last  = ~s1_emit2;
    end else begin
      push.first = push.second;
    end
    push.n = s1_go ? (2'(s1_emit1) + 2'(s1_emit2)) : 2'd0;
  end

  lsh_out_fifo u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .space_two (space_two),
    .res_valid (result_valid),
    .res_ready (result_ready),
    .res       (res)
  );

  assign out_value   = res.value;
  assign last_of_run = res.last;

  `LSH_ASSERT_NEXT(a_accept_fills_stage, clk, rst, accept, s1_valid)
  `LSH_ASSERT_NEXT(a_stalled_stage_holds, clk, rst, s1_valid && !space_two,
                   s1_valid && $stable(s1_sample) && $stable(s1_emit2))
  `LSH_ASSERT_IMPL(a_interior_emits, clk, rst, s1_valid && s1_interior, s1_emit1)
  `LSH_ASSERT_IMPL(a_empty_stage_ready, clk, rst, !s1_valid, sample_ready)

endmodule
